### rtl/core/rzt_pkg.sv
// ----------------------------------------------------------------------------
// Rectangular zone table: shared package
// Command and status codes, and the records that pass between the front
// part, the work queue, the back part and the result queue.
// ----------------------------------------------------------------------------
package rzt_pkg;

   // Widths of the fixed fields
   localparam int CMD_W    = 2;
   localparam int IDX_W    = 4;
   localparam int POS_W    = 16;
   localparam int SIZE_W   = 16;
   localparam int EDGE_W   = 18;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Largest number of entries that the index field can address
   localparam int INDEX_SPAN = 16;

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_DEFINE = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_READ   = 2'd2,
      CMD_WRITE  = 2'd3
   } cmd_type;

   // Status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_RANGE    = 2'd1,
      STAT_INACTIVE = 2'd2
   } status_type;

   // A classified command, as the front part hands it to the back part
   typedef struct packed {
      cmd_type                   cmd;
      logic [IDX_W-1:0]          idx;
      logic                      in_range;
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic signed [EDGE_W-1:0]  right;
      logic signed [EDGE_W-1:0]  bottom;
      logic [VALUE_W-1:0]        value;
   } work_type;

   // One result item
   typedef struct packed {
      logic                      found;
      logic [IDX_W-1:0]          hit_index;
      logic [VALUE_W-1:0]        read_value;
      status_type                status;
   } result_type;

endpackage

### rtl/core/rzt_fifo.sv
// ----------------------------------------------------------------------------
// Rectangular zone table: small queue
// A shallow first-in first-out queue that parts two sides of the block.
// Full and empty come straight from a registered fill count.
// ----------------------------------------------------------------------------
module rzt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   // Pointer and count update; pointers wrap at the last slot.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots hold no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### rtl/core/rzt_front.sv
// ----------------------------------------------------------------------------
// Rectangular zone table: front part
// Classifies each incoming command: checks the entry index against the
// count in use and works out the right and bottom edges of a zone two
// bits wider than the position, so that they never wrap.
// ----------------------------------------------------------------------------
module rzt_front (
   input  logic [1:0]                          cmd,
   input  logic [3:0]                          entry_index,
   input  logic signed [15:0]                  pos_x,
   input  logic signed [15:0]                  pos_y,
   input  logic [15:0]                         zone_width,
   input  logic [15:0]                         zone_height,
   input  logic signed [31:0]                  new_value,
   input  logic [rzt_pkg::COUNT_W-1:0]         live_count,
   output rzt_pkg::work_type                   work
);
   import rzt_pkg::*;

   logic signed [EDGE_W-1:0] left_wide;
   logic signed [EDGE_W-1:0] top_wide;
   logic signed [EDGE_W-1:0] width_wide;
   logic signed [EDGE_W-1:0] height_wide;

   // Sign-extend the origin and zero-extend the size before the add.
   assign left_wide   = EDGE_W'(pos_x);
   assign top_wide    = EDGE_W'(pos_y);
   assign width_wide  = $signed({{(EDGE_W-SIZE_W){1'b0}}, zone_width});
   assign height_wide = $signed({{(EDGE_W-SIZE_W){1'b0}}, zone_height});

   // Build the classified record. A zero size gives an edge left of the
   // origin, so the zone contains no point.
   always_comb begin
      work.cmd      = cmd_type'(cmd);
      work.idx      = entry_index;
      work.in_range = ({1'b0, entry_index} < live_count);
      work.pos_x    = pos_x;
      work.pos_y    = pos_y;
      work.right    = left_wide + width_wide - EDGE_W'(1);
      work.bottom   = top_wide + height_wide - EDGE_W'(1);
      work.value    = new_value;
   end

endmodule

### rtl/core/rzt_back.sv
// ----------------------------------------------------------------------------
// Rectangular zone table: back part
// Holds the zone table and carries out one classified command per exec cycle.
// Each zone cell compares the point against its own edges, and a priority
// pick returns the lowest containing index.
// ----------------------------------------------------------------------------
module rzt_back #(
   parameter int DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        exec,
   input  rzt_pkg::work_type           work,
   input  logic [rzt_pkg::COUNT_W-1:0] live_count,
   output rzt_pkg::result_type         result
);
   import rzt_pkg::*;

   // Zone table; payload fields carry no reset, the active marks do.
   logic signed [POS_W-1:0]  left_ff   [DEPTH];
   logic signed [POS_W-1:0]  top_ff    [DEPTH];
   logic signed [EDGE_W-1:0] right_ff  [DEPTH];
   logic signed [EDGE_W-1:0] bottom_ff [DEPTH];
   logic [VALUE_W-1:0]       value_ff  [DEPTH];
   logic [DEPTH-1:0]         active_ff, active_in;

   logic [DEPTH-1:0]         hit_vec;
   logic [DEPTH-1:0]         sel_vec;
   logic signed [EDGE_W-1:0] px_wide;
   logic signed [EDGE_W-1:0] py_wide;
   logic                     any_hit;
   logic [IDX_W-1:0]         hit_idx;
   logic [VALUE_W-1:0]       sel_value;
   logic                     sel_active;
   logic                     do_define;
   logic                     do_write;

   assign px_wide = EDGE_W'(work.pos_x);
   assign py_wide = EDGE_W'(work.pos_y);

   // Per-cell containment test and entry select.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         hit_vec[i] = active_ff[i] && (COUNT_W'(i) < live_count)
                      && (EDGE_W'(left_ff[i]) <= px_wide) && (px_wide <= right_ff[i])
                      && (EDGE_W'(top_ff[i]) <= py_wide) && (py_wide <= bottom_ff[i]);
         sel_vec[i] = (work.idx == IDX_W'(i));
      end
   end

   // Lowest containing index wins.
   always_comb begin
      any_hit = |hit_vec;
      hit_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_idx = IDX_W'(i);
         end
      end
   end

   // Value and active mark of the addressed entry.
   always_comb begin
      sel_value  = '0;
      sel_active = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         if (sel_vec[i]) begin
            sel_value  = value_ff[i];
            sel_active = active_ff[i];
         end
      end
   end

   // Result of the command now in execution.
   always_comb begin
      result.found      = 1'b0;
      result.hit_index  = '0;
      result.read_value = '0;
      result.status     = STAT_OK;
      unique case (work.cmd)
         CMD_LOOKUP: begin
            result.found     = any_hit;
            result.hit_index = hit_idx;
         end
         CMD_READ: begin
            if (!work.in_range) begin
               result.status = STAT_RANGE;
            end else if (!sel_active) begin
               result.status = STAT_INACTIVE;
            end else begin
               result.read_value = sel_value;
            end
         end
         CMD_DEFINE, CMD_WRITE: begin
            if (!work.in_range) begin
               result.status = STAT_RANGE;
            end
         end
         default: begin
            result.status = STAT_OK;
         end
      endcase
   end

   assign do_define = exec && work.in_range && (work.cmd == CMD_DEFINE);
   assign do_write  = exec && work.in_range && (work.cmd == CMD_WRITE);

   // A define marks its entry active; nothing clears a mark but reset.
   always_comb begin
      active_in = active_ff;
      for (int i = 0; i < DEPTH; i++) begin
         if (do_define && sel_vec[i]) begin
            active_in[i] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         active_ff <= active_in;
      end
   end

   // Table payload update.
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (do_define && sel_vec[i]) begin
            left_ff[i]   <= work.pos_x;
            top_ff[i]    <= work.pos_y;
            right_ff[i]  <= work.right;
            bottom_ff[i] <= work.bottom;
         end
         if ((do_define || do_write) && sel_vec[i]) begin
            value_ff[i] <= work.value;
         end
      end
   end

endmodule

### rtl/core/rect_zone_table_lookup.sv
// ----------------------------------------------------------------------------
// Rectangular zone table lookup: top level
// Path: an accepted command is registered in the work queue; the back part
// then executes it into the result queue, which drives the result ports.
// Throughput: one command per cycle while the result queue has room; the
// back part runs any command combinationally; zone cells compare in parallel.
// Reset: synchronous, active high; clears the queues and all active marks,
// and sets the zone count to 16. Zone payload is undefined until defined.
// ----------------------------------------------------------------------------
module rect_zone_table_lookup #(
   parameter int MAX_ZONES = 16
) (
   input  logic               clock,
   input  logic               reset,
   // Command channel
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_cmd,
   input  logic [3:0]         req_entry_index,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [15:0]        req_zone_width,
   input  logic [15:0]        req_zone_height,
   input  logic signed [31:0] req_new_value,
   // Result channel
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic               rsp_found,
   output logic [3:0]         rsp_hit_index,
   output logic signed [31:0] rsp_read_value,
   output logic [1:0]         rsp_status,
   // Configuration channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [4:0]         csr_zone_count
);
   import rzt_pkg::*;

   localparam int DEPTH = (MAX_ZONES < INDEX_SPAN) ? MAX_ZONES : INDEX_SPAN;
   localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH);
   localparam int WORK_W   = $bits(work_type);
   localparam int RESULT_W = $bits(result_type);

   logic [COUNT_W-1:0] zone_count_ff, zone_count_in;
   logic [COUNT_W-1:0] live_count;
   work_type           front_work;
   work_type           back_work;
   logic [WORK_W-1:0]  back_work_bits;
   result_type         back_result;
   result_type         rsp_result;
   logic [RESULT_W-1:0] rsp_result_bits;
   logic               work_empty;
   logic               result_full;
   logic               exec;

   // Zone count register; a transfer on the configuration channel writes it.
   assign csr_ready     = 1'b1;
   assign zone_count_in = (csr_valid && csr_ready) ? csr_zone_count : zone_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_count_ff <= COUNT_W'(INDEX_SPAN);
      end else begin
         zone_count_ff <= zone_count_in;
      end
   end

   // Count in use, saturated to the table depth.
   assign live_count = (zone_count_ff > DEPTH_CNT) ? DEPTH_CNT : zone_count_ff;

   // Front part: classify the incoming command.
   rzt_front u_front (
      .cmd         (req_cmd),
      .entry_index (req_entry_index),
      .pos_x       (req_pos_x),
      .pos_y       (req_pos_y),
      .zone_width  (req_zone_width),
      .zone_height (req_zone_height),
      .new_value   (req_new_value),
      .live_count  (live_count),
      .work        (front_work)
   );

   // Work queue between front and back.
   rzt_fifo #(
      .WIDTH (WORK_W),
      .DEPTH (2)
   ) u_work_q (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (front_work),
      .full    (req_full),
      .pop     (exec),
      .rd_data (back_work_bits),
      .empty   (work_empty)
   );

   assign back_work = work_type'(back_work_bits);
   assign exec      = !work_empty && !result_full;

   // Back part: table and execution.
   rzt_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .exec       (exec),
      .work       (back_work),
      .live_count (live_count),
      .result     (back_result)
   );

   // Result queue toward the result channel.
   rzt_fifo #(
      .WIDTH (RESULT_W),
      .DEPTH (2)
   ) u_result_q (
      .clock   (clock),
      .reset   (reset),
      .push    (exec),
      .wr_data (back_result),
      .full    (result_full),
      .pop     (rsp_pop),
      .rd_data (rsp_result_bits),
      .empty   (rsp_empty)
   );

   assign rsp_result     = result_type'(rsp_result_bits);
   assign rsp_found      = rsp_result.found;
   assign rsp_hit_index  = rsp_result.hit_index;
   assign rsp_read_value = $signed(rsp_result.read_value);
   assign rsp_status     = rsp_result.status;

   // An accepted command is waiting in the work queue in the following cycle.
   a_work_held : assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> !work_empty)
      else $error("accepted command missing from work queue");

   // A found zone always comes with status ok.
   a_found_ok : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_found) |-> (rsp_status == STAT_OK))
      else $error("lookup hit carries a nonzero status");

   // No hit means a zero hit index.
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_found) |-> (rsp_hit_index == '0))
      else $error("hit index nonzero without a hit");

   // A failing status never carries a read value.
   a_err_no_value : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_status != STAT_OK)) |-> (rsp_read_value == '0))
      else $error("read value present with error status");

endmodule
